[src/espt_pkg.sv]
package espt_pkg;

  // Number of orders held in the column (cells in the chain)
  localparam int MAX_ORDER = 16;

  localparam int ORDER_W = 5;
  localparam int EIG_W   = 32;
  localparam int POLY_W  = 64;

  // 1.0 in Q40.24
  localparam logic [POLY_W-1:0] ONE_Q24 = POLY_W'(1) << 24;

  localparam logic [ORDER_W-1:0] MAX_ORDER_CODE = ORDER_W'(MAX_ORDER);

  typedef struct packed {
    logic [EIG_W-1:0] eigen_value;
    logic             first_value;
  } in_item_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order_index;
    logic [POLY_W-1:0]  poly_value;
    logic               last_of_column;
  } out_item_t;

  // Step strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic latch;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic accum;
    logic shift;
  } cell_ctl_t;

  // Order register: zero reads as one, anything above the column depth as the depth
  function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] k);
    logic [ORDER_W-1:0] r;
    if (k == '0) begin
      r = ORDER_W'(1);
    end else if (k > MAX_ORDER_CODE) begin
      r = MAX_ORDER_CODE;
    end else begin
      r = k;
    end
    return r;
  endfunction

endpackage

[src/espt_cell.sv]
// One order of the column: holds e_i and updates it from its lower neighbour.
module espt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  espt_pkg::cell_ctl_t        ctl,
  input  logic [espt_pkg::EIG_W-1:0]  eigen,
  input  logic [espt_pkg::POLY_W-1:0] below_in,
  input  logic [espt_pkg::POLY_W-1:0] out_in,
  output logic [espt_pkg::POLY_W-1:0] e_q,
  output logic [espt_pkg::POLY_W-1:0] out_q
);

  logic [espt_pkg::POLY_W-1:0] e_r, e_nxt;
  logic [espt_pkg::POLY_W-1:0] below_r;
  logic [espt_pkg::POLY_W-1:0] plo_r, phi_r;
  logic [espt_pkg::POLY_W-1:0] m_r, m_nxt;
  logic [espt_pkg::POLY_W-1:0] out_r;

  logic [31:0]                 mul_op;
  logic [espt_pkg::POLY_W-1:0] prod;
  logic                        hi_ovf;
  logic [espt_pkg::POLY_W:0]   scaled;
  logic [espt_pkg::POLY_W:0]   acc;

  // One 32x32 multiplier, used on the low then the high half of e_(i-1)
  assign mul_op = ctl.mul_hi ? below_r[63:32] : below_r[31:0];
  assign prod   = espt_pkg::POLY_W'(eigen) * espt_pkg::POLY_W'(mul_op);

  // (d * e) >> 24 with saturation
  assign hi_ovf = (phi_r[63:56] != 8'd0);
  assign scaled = {1'b0, phi_r[55:0], 8'd0} + {25'd0, plo_r[63:24]};
  assign m_nxt  = (hi_ovf || scaled[64]) ? '1 : scaled[63:0];

  // Saturating accumulate into the held order
  assign acc   = {1'b0, e_r} + {1'b0, m_r};
  assign e_nxt = acc[64] ? '1 : acc[63:0];

  // Column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= '0;
    end else if (ctl.clear) begin
      e_r <= '0;
    end else if (ctl.accum) begin
      e_r <= e_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.latch) below_r <= below_in;
    if (ctl.mul_lo) plo_r <= prod;
    if (ctl.mul_hi) phi_r <= prod;
    if (ctl.scale) m_r <= m_nxt;
  end

  // Readout line: loaded with the new value, shifted down one order per transfer
  always_ff @(posedge clk) begin
    if (ctl.accum) begin
      out_r <= e_nxt;
    end else if (ctl.shift) begin
      out_r <= out_in;
    end
  end

  assign e_q   = e_r;
  assign out_q = out_r;

endmodule

[src/espt_seq.sv]
// Item sequencer: steps the cells through one update, then emits the column.
module espt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  espt_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [espt_pkg::ORDER_W-1:0]  order_index,
  output logic                          last_of_column,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [espt_pkg::ORDER_W-1:0]  cfg_data,
  output espt_pkg::cell_ctl_t           ctl,
  output logic [espt_pkg::EIG_W-1:0]    eigen
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LATCH,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_ACCUM,
    S_EMIT
  } state_t;

  state_t                        state_r;
  logic [espt_pkg::EIG_W-1:0]    eigen_r;
  logic [espt_pkg::ORDER_W-1:0]  orders_r;
  logic [espt_pkg::ORDER_W-1:0]  k_r;
  logic [espt_pkg::ORDER_W-1:0]  cnt_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign order_index    = cnt_r;
  assign last_of_column = (cnt_r == k_r);
  assign eigen     = eigen_r;

  // Step strobes
  always_comb begin
    ctl        = '0;
    ctl.clear  = (state_r == S_CLEAR);
    ctl.latch  = (state_r == S_LATCH);
    ctl.mul_lo = (state_r == S_MUL_LO);
    ctl.mul_hi = (state_r == S_MUL_HI);
    ctl.scale  = (state_r == S_SCALE);
    ctl.accum  = (state_r == S_ACCUM);
    ctl.shift  = (state_r == S_EMIT) && out_ready;
  end

  // Order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orders_r <= espt_pkg::MAX_ORDER_CODE;
    end else if (cfg_valid && cfg_ready) begin
      orders_r <= cfg_data;
    end
  end

  // State and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= espt_pkg::MAX_ORDER_CODE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            eigen_r <= in_data.eigen_value;
            k_r     <= espt_pkg::clamp_order(orders_r);
            cnt_r   <= espt_pkg::ORDER_W'(1);
            state_r <= in_data.first_value ? S_CLEAR : S_LATCH;
          end
        end
        S_CLEAR:  state_r <= S_LATCH;
        S_LATCH:  state_r <= S_MUL_LO;
        S_MUL_LO: state_r <= S_MUL_HI;
        S_MUL_HI: state_r <= S_SCALE;
        S_SCALE:  state_r <= S_ACCUM;
        S_ACCUM:  state_r <= S_EMIT;
        S_EMIT: begin
          if (out_ready) begin
            if (cnt_r == k_r) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + espt_pkg::ORDER_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/elementary_symmetric_poly_table_unit.sv]
// Streaming elementary symmetric polynomial column. Each eigenvalue (unsigned Q8.24)
// taken on the in_ channel updates every order of a 16-deep column of e_i (unsigned
// Q40.24, saturating at all ones) as e_i + d*e_(i-1), with e_0 = 1.0; first_value set
// clears the column beforehand. The block then emits orders 1..k, one per out_
// transfer, last_of_column marking order k, where k is the orders_in_use register
// (written on the cfg_ port, reset 16, zero read as 1, above 16 read as 16). Each item
// goes through the input transfer, an optional clear step, then five update steps
// (latch, low multiply, high multiply, scale, accumulate) through a chain of per-order
// cells, each with one 32x32 multiplier used twice, then the emit state, in which the
// column shifts out through the cells, one order per out_ transfer. A new item is taken
// only once the previous column is out.
module elementary_symmetric_poly_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  espt_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output espt_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [espt_pkg::ORDER_W-1:0]  cfg_data
);

  espt_pkg::cell_ctl_t            ctl;
  logic [espt_pkg::EIG_W-1:0]     eigen;
  logic [espt_pkg::ORDER_W-1:0]   order_index;
  logic                           last_of_column;

  logic [espt_pkg::POLY_W-1:0] e_w   [espt_pkg::MAX_ORDER];
  logic [espt_pkg::POLY_W-1:0] out_w [espt_pkg::MAX_ORDER];

  espt_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .order_index    (order_index),
    .last_of_column (last_of_column),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .ctl            (ctl),
    .eigen          (eigen)
  );

  // Chain of cells: order 1 sees 1.0 below it, the top order's readout takes zeros
  for (genvar i = 0; i < espt_pkg::MAX_ORDER; i++) begin : g_cell
    logic [espt_pkg::POLY_W-1:0] below;
    logic [espt_pkg::POLY_W-1:0] above_out;

    if (i == 0) begin : g_bottom
      assign below = espt_pkg::ONE_Q24;
    end else begin : g_mid
      assign below = e_w[i-1];
    end

    if (i == espt_pkg::MAX_ORDER - 1) begin : g_top
      assign above_out = '0;
    end else begin : g_inner
      assign above_out = out_w[i+1];
    end

    espt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .eigen    (eigen),
      .below_in (below),
      .out_in   (above_out),
      .e_q      (e_w[i]),
      .out_q    (out_w[i])
    );
  end

  // Result payload
  assign out_data.order_index    = order_index;
  assign out_data.poly_value     = out_w[0];
  assign out_data.last_of_column = last_of_column;

endmodule

[src/espt_checker.sv]
// Port-level checks for the polynomial table unit.
module espt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input espt_pkg::out_item_t  out_data
);

  // Input and output never open together: one column at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a column is being emitted");

  // No result straight after an input transfer
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result shown before the update ran");

  // Column ends on its last entry
  a_col_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_of_column) |=> (!out_valid && in_ready))
    else $error("output kept going past the last order");

  // Orders follow on by one within a column
  a_order_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_column) |=>
      (out_valid && out_data.order_index == $past(out_data.order_index) + 5'd1))
    else $error("order index did not advance by one");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind elementary_symmetric_poly_table_unit espt_checker u_espt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
